[hdl/asbc_pkg.sv]
`timescale 1ns / 1ps

package asbc_pkg;

    // Default grid size in bins.
    localparam int GRID_WIDTH_DEF  = 64;
    localparam int GRID_HEIGHT_DEF = 64;

    // Field widths.
    localparam int IDX_W   = 6;
    localparam int COEFF_W = 24;
    localparam int FREQ_W  = 40;
    localparam int MAG_W   = 47;
    localparam int EN_W    = 60;
    localparam int CNT_W   = 13;
    localparam int FRAC_W  = 17;
    localparam int ROOT_W  = 41;
    localparam int MUL_W   = 40;
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;

    localparam logic [31:0]        PITCH_RESET = 32'd256;
    localparam logic [MAG_W-1:0]   MAG_MAX     = {MAG_W{1'b1}};
    localparam logic [EN_W-1:0]    ENERGY_MAX  = {EN_W{1'b1}};
    localparam logic [CNT_W-1:0]   COUNT_MAX   = {CNT_W{1'b1}};
    localparam logic [FRAC_W-1:0]  FRAC_ONE    = 17'd65536;
    localparam logic signed [63:0] F_MAX       = 64'sd549755813887;
    localparam logic signed [63:0] F_MIN       = -64'sd549755813888;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_PITCH_X = 2'd0;
    localparam logic [1:0] REG_PITCH_Y = 2'd1;
    localparam logic [1:0] REG_CUTOFF  = 2'd2;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_QUERY   = 2'd1,
        OP_SUMMARY = 2'd2,
        OP_CLEAR   = 2'd3
    } opcode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RDWAIT,
        ST_MRE,
        ST_MIM,
        ST_SQX,
        ST_SQY,
        ST_SQC,
        ST_CLASS,
        ST_SQRT1,
        ST_SQRT2,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

[hdl/asbc_if.sv]
`timescale 1ns / 1ps

// Request channel: one operation per transaction.
interface asbc_req_if;
    logic                                     valid;
    logic                                     ready;
    logic [1:0]                               opcode;
    logic [asbc_pkg::IDX_W-1:0]               col;
    logic [asbc_pkg::IDX_W-1:0]               row;
    logic signed [asbc_pkg::COEFF_W-1:0]      coeff_re;
    logic signed [asbc_pkg::COEFF_W-1:0]      coeff_im;

    modport source (output valid, opcode, col, row, coeff_re, coeff_im, input ready);
    modport sink   (input valid, opcode, col, row, coeff_re, coeff_im, output ready);
endinterface

// Response channel: one result per summary query or in-grid bin query.
interface asbc_rsp_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [asbc_pkg::FREQ_W-1:0]       freq_x;
    logic signed [asbc_pkg::FREQ_W-1:0]       freq_y;
    logic [asbc_pkg::FREQ_W-1:0]              radial;
    logic signed [asbc_pkg::COEFF_W-1:0]      bin_re;
    logic signed [asbc_pkg::COEFF_W-1:0]      bin_im;
    logic [asbc_pkg::FRAC_W-1:0]              intensity;
    logic                                     bin_class;
    logic [asbc_pkg::FREQ_W-1:0]              axial_or_decay;
    logic [asbc_pkg::CNT_W-1:0]               prop_count;
    logic [asbc_pkg::CNT_W-1:0]               evan_count;
    logic [asbc_pkg::FRAC_W-1:0]              prop_fraction;
    logic                                     energy_zero;

    modport source (output valid, freq_x, freq_y, radial, bin_re, bin_im, intensity,
                    bin_class, axial_or_decay, prop_count, evan_count, prop_fraction,
                    energy_zero, input ready);
    modport sink   (input valid, freq_x, freq_y, radial, bin_re, bin_im, intensity,
                    bin_class, axial_or_decay, prop_count, evan_count, prop_fraction,
                    energy_zero, output ready);
endinterface

[hdl/asbc_ram.sv]
`timescale 1ns / 1ps

module asbc_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/asbc_mul.sv]
`timescale 1ns / 1ps

module asbc_mul #(
    parameter int W = 40
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [W-1:0]   a,
    input  logic [W-1:0]   b,
    output logic           done,
    output logic [2*W-1:0] prod
);

    localparam int CW = $clog2(W + 1);

    logic           busy_reg;
    logic           done_reg;
    logic [CW-1:0]  cnt_reg;
    logic [W-1:0]   a_reg;
    logic [W-1:0]   b_reg;
    logic [2*W-1:0] acc_reg;

    // Control: count W shift-add steps, then flag completion for one cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: most significant multiplier bit first.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= {acc_reg[2*W-2:0], 1'b0}
                       + {{W{1'b0}}, (b_reg[W-1] ? a_reg : {W{1'b0}})};
            b_reg   <= {b_reg[W-2:0], 1'b0};
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

[hdl/asbc_sqrt.sv]
`timescale 1ns / 1ps

module asbc_sqrt #(
    parameter int RW = 41
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [2*RW-1:0] val,
    output logic            done,
    output logic [RW-1:0]   root
);

    localparam int CW = $clog2(RW + 1);

    logic            busy_reg;
    logic            done_reg;
    logic [CW-1:0]   cnt_reg;
    logic [2*RW-1:0] v_reg;
    logic [RW+1:0]   rem_reg;
    logic [RW-1:0]   root_reg;
    logic [RW+2:0]   rem_sh;
    logic [RW+2:0]   trial;
    logic            fits;

    // One root bit per cycle: bring down two bits and try the next digit.
    always_comb
    begin
        rem_sh = {rem_reg[RW:0], v_reg[2*RW-1:2*RW-2]};
        trial  = {1'b0, root_reg, 2'b01};
        fits   = (rem_sh >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(RW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg    <= val;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            v_reg <= {v_reg[2*RW-3:0], 2'b00};
            if (fits)
            begin
                rem_reg  <= (RW+2)'(rem_sh - trial);
                root_reg <= {root_reg[RW-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh[RW+1:0];
                root_reg <= {root_reg[RW-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

[hdl/angular_spectrum_bin_classifier.sv]
`timescale 1ns / 1ps

// Angular spectrum bin classifier.
// The req channel carries one operation per transaction: load a coefficient
// (natural FFT order), query a centred bin, query the frame summary, or clear
// the frame. Loads and clears give no response; each summary query and each
// in-grid bin query gives exactly one transaction on the rsp channel. pitch_x,
// pitch_y and cutoff are written over the APB port at byte addresses 0, 4 and
// 8; the user must write them only while the block is idle, which the block
// itself does not enforce. One item is in work at a time; req.ready is high
// only when idle. Squares, roots and divides run on a 40-step serial
// multiplier, a 41-step serial square root and a 16-step divider: a load uses
// five squares, a bin query five squares, two roots and one divide, a summary one divide.
// A response waits in the output register while the receiver stalls; the
// next item is already accepted and worked on, and only its own response
// waits for the register to drain.
// Reset clears the energies, counts, maximum and sets the registers to 1.0;
// the coefficient store keeps no reset value, so reading an unloaded bin
// returns arbitrary coefficient data.
module angular_spectrum_bin_classifier #(
    parameter int GRID_WIDTH  = asbc_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = asbc_pkg::GRID_HEIGHT_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    asbc_req_if.sink                    req,
    asbc_rsp_if.source                  rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [asbc_pkg::APB_AW-1:0] paddr,
    input  logic [asbc_pkg::APB_DW-1:0] pwdata,
    output logic [asbc_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);

    localparam int DEPTH = GRID_WIDTH * GRID_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int MAXG  = (GRID_WIDTH > GRID_HEIGHT) ? GRID_WIDTH : GRID_HEIGHT;
    localparam int IW    = $clog2(MAXG) + 1;
    localparam int PW    = IW + 33;
    localparam int CX    = GRID_WIDTH / 2;
    localparam int CY    = GRID_HEIGHT / 2;
    localparam int FW    = asbc_pkg::FREQ_W;
    localparam int CFW   = asbc_pkg::COEFF_W;
    localparam int MW    = asbc_pkg::MUL_W;
    localparam int RW    = asbc_pkg::ROOT_W;
    localparam int EW    = asbc_pkg::EN_W;
    localparam int MAGW  = asbc_pkg::MAG_W;
    localparam int NW    = asbc_pkg::CNT_W;
    localparam int QW    = asbc_pkg::FRAC_W;

    // Signed index times pitch, saturated to the frequency range.
    function automatic logic signed [FW-1:0] sat_freq(input logic signed [IW-1:0] s,
                                                      input logic [31:0] p);
        logic signed [PW-1:0] prod;
        logic signed [63:0]   ext;
        prod = s * $signed({1'b0, p});
        ext  = 64'(prod);
        if (ext > asbc_pkg::F_MAX)
        begin
            sat_freq = FW'(asbc_pkg::F_MAX);
        end
        else if (ext < asbc_pkg::F_MIN)
        begin
            sat_freq = FW'(asbc_pkg::F_MIN);
        end
        else
        begin
            sat_freq = FW'(ext);
        end
    endfunction

    asbc_pkg::state_t state_reg, state_next;
    logic             launch_reg, launch_next;

    // Configuration registers.
    logic [31:0] pitch_x_reg;
    logic [31:0] pitch_y_reg;
    logic [31:0] cutoff_reg;

    // Frame accumulators.
    logic [MAGW-1:0] max_reg;
    logic [EW-1:0]   prop_reg;
    logic [EW-1:0]   total_reg;
    logic [NW-1:0]   pcnt_reg;
    logic [NW-1:0]   ecnt_reg;

    // Per-item working registers.
    asbc_pkg::opcode_t      op_reg;
    logic signed [FW-1:0]   fx_reg;
    logic signed [FW-1:0]   fy_reg;
    logic signed [CFW-1:0]  re_reg;
    logic signed [CFW-1:0]  im_reg;
    logic [MAGW-1:0]        re2_reg;
    logic [MAGW-1:0]        m_reg;
    logic [2*MW-1:0]        sqx_reg;
    logic [2*MW-1:0]        sqy_reg;
    logic [2*MW-1:0]        csq_reg;
    logic [2*MW:0]          sq_reg;
    logic [2*MW:0]          diff_reg;
    logic                   cls_reg;
    logic [FW-1:0]          radial_reg;
    logic [FW-1:0]          axial_reg;
    logic [EW:0]            div_r_reg;
    logic [QW-1:0]          div_q_reg;
    logic [4:0]             div_cnt_reg;

    // Output register.
    logic                   out_valid_reg;
    logic signed [FW-1:0]   o_fx_reg;
    logic signed [FW-1:0]   o_fy_reg;
    logic [FW-1:0]          o_radial_reg;
    logic signed [CFW-1:0]  o_re_reg;
    logic signed [CFW-1:0]  o_im_reg;
    logic [QW-1:0]          o_inten_reg;
    logic                   o_cls_reg;
    logic [FW-1:0]          o_axial_reg;
    logic [NW-1:0]          o_pcnt_reg;
    logic [NW-1:0]          o_ecnt_reg;
    logic [QW-1:0]          o_frac_reg;
    logic                   o_ez_reg;

    // Request decode.
    asbc_pkg::opcode_t      req_op;
    logic                   req_fire;
    logic                   in_grid;
    int                     colv;
    int                     rowv;
    int                     sx_int;
    int                     sy_int;
    int                     nx_int;
    int                     ny_int;
    int                     addr_int;
    logic signed [IW-1:0]   sidx_x;
    logic signed [IW-1:0]   sidx_y;
    logic [AW-1:0]          addr;
    logic [2*CFW-1:0]       rdata;

    assign req_op   = asbc_pkg::opcode_t'(req.opcode);
    assign req.ready = (state_reg == asbc_pkg::ST_IDLE);
    assign req_fire = req.valid && req.ready;

    // Index mapping: natural order for loads, centred order for queries.
    always_comb
    begin
        colv   = int'(req.col);
        rowv   = int'(req.row);
        in_grid = (colv < GRID_WIDTH) && (rowv < GRID_HEIGHT);
        nx_int = (colv >= CX) ? colv - CX : colv + GRID_WIDTH - CX;
        ny_int = (rowv >= CY) ? rowv - CY : rowv + GRID_HEIGHT - CY;
        if (req_op == asbc_pkg::OP_LOAD)
        begin
            sx_int   = (colv < GRID_WIDTH - CX) ? colv : colv - GRID_WIDTH;
            sy_int   = (rowv < GRID_HEIGHT - CY) ? rowv : rowv - GRID_HEIGHT;
            addr_int = rowv * GRID_WIDTH + colv;
        end
        else
        begin
            sx_int   = colv - CX;
            sy_int   = rowv - CY;
            addr_int = ny_int * GRID_WIDTH + nx_int;
        end
        sidx_x = IW'(sx_int);
        sidx_y = IW'(sy_int);
        addr   = AW'(addr_int);
    end

    asbc_ram #(
        .WIDTH (2 * CFW),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (req_fire && (req_op == asbc_pkg::OP_LOAD) && in_grid),
        .waddr (addr),
        .wdata ({req.coeff_im, req.coeff_re}),
        .raddr (addr),
        .rdata (rdata)
    );

    // Shared multiplier: operands follow the current step.
    logic            mul_start;
    logic            mul_done;
    logic [MW-1:0]   mul_op;
    logic [2*MW-1:0] mul_prod;
    logic [CFW-1:0]  abs_re;
    logic [CFW-1:0]  abs_im;
    logic [FW-1:0]   abs_fx;
    logic [FW-1:0]   abs_fy;

    always_comb
    begin
        abs_re = re_reg[CFW-1] ? CFW'(-re_reg) : CFW'(re_reg);
        abs_im = im_reg[CFW-1] ? CFW'(-im_reg) : CFW'(im_reg);
        abs_fx = fx_reg[FW-1] ? FW'(-fx_reg) : FW'(fx_reg);
        abs_fy = fy_reg[FW-1] ? FW'(-fy_reg) : FW'(fy_reg);
        unique case (state_reg)
            asbc_pkg::ST_MRE: mul_op = MW'(abs_re);
            asbc_pkg::ST_MIM: mul_op = MW'(abs_im);
            asbc_pkg::ST_SQX: mul_op = MW'(abs_fx);
            asbc_pkg::ST_SQY: mul_op = MW'(abs_fy);
            default:          mul_op = MW'(cutoff_reg);
        endcase
        mul_start = launch_reg && ((state_reg == asbc_pkg::ST_MRE)
                                   || (state_reg == asbc_pkg::ST_MIM)
                                   || (state_reg == asbc_pkg::ST_SQX)
                                   || (state_reg == asbc_pkg::ST_SQY)
                                   || (state_reg == asbc_pkg::ST_SQC));
    end

    asbc_mul #(
        .W (MW)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_op),
        .b     (mul_op),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    // Shared square root.
    logic            sqrt_start;
    logic            sqrt_done;
    logic [RW-1:0]   sqrt_root;

    assign sqrt_start = launch_reg && ((state_reg == asbc_pkg::ST_SQRT1)
                                       || (state_reg == asbc_pkg::ST_SQRT2));

    asbc_sqrt #(
        .RW (RW)
    ) u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .val   ((state_reg == asbc_pkg::ST_SQRT1) ? (2*RW)'(sq_reg) : (2*RW)'(diff_reg)),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    // Magnitude, classification and divider operands.
    logic [MAGW:0]   mag_sum;
    logic [MAGW-1:0] mag_sat;
    logic [2*MW:0]   sq_cur;
    logic            cls_cur;
    logic [2*MW:0]   diff_cur;
    logic [EW:0]     prop_sum;
    logic [EW:0]     total_sum;
    logic [EW-1:0]   div_num;
    logic [EW-1:0]   div_den;
    logic [EW:0]     div_r2;
    logic            div_short;

    always_comb
    begin
        mag_sum   = {1'b0, re2_reg} + {1'b0, mul_prod[MAGW-1:0]};
        mag_sat   = mag_sum[MAGW] ? asbc_pkg::MAG_MAX : mag_sum[MAGW-1:0];
        sq_cur    = {1'b0, sqx_reg} + {1'b0, sqy_reg};
        cls_cur   = !(sq_cur <= {1'b0, csq_reg});
        diff_cur  = cls_cur ? (sq_cur - {1'b0, csq_reg}) : ({1'b0, csq_reg} - sq_cur);
        prop_sum  = {1'b0, prop_reg} + (EW+1)'(m_reg);
        total_sum = {1'b0, total_reg} + (EW+1)'(m_reg);
        if (op_reg == asbc_pkg::OP_SUMMARY)
        begin
            div_num = prop_reg;
            div_den = total_reg;
        end
        else
        begin
            div_num = EW'(m_reg);
            div_den = EW'(max_reg);
        end
        div_short = (div_den == '0) || (div_num >= div_den);
        div_r2    = {div_r_reg[EW-1:0], 1'b0};
    end

    // Sequencer: next state and unit launches.
    always_comb
    begin
        state_next  = state_reg;
        launch_next = 1'b0;
        unique case (state_reg)
            asbc_pkg::ST_IDLE:
            begin
                if (req_fire)
                begin
                    unique case (req_op)
                        asbc_pkg::OP_LOAD:
                        begin
                            if (in_grid)
                            begin
                                state_next  = asbc_pkg::ST_MRE;
                                launch_next = 1'b1;
                            end
                        end
                        asbc_pkg::OP_QUERY:
                        begin
                            if (in_grid)
                            begin
                                state_next = asbc_pkg::ST_RDWAIT;
                            end
                        end
                        asbc_pkg::OP_SUMMARY:
                        begin
                            state_next  = asbc_pkg::ST_DIV;
                            launch_next = 1'b1;
                        end
                        asbc_pkg::OP_CLEAR:
                        begin
                            state_next = asbc_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            asbc_pkg::ST_RDWAIT:
            begin
                state_next  = asbc_pkg::ST_MRE;
                launch_next = 1'b1;
            end
            asbc_pkg::ST_MRE:
            begin
                if (mul_done)
                begin
                    state_next  = asbc_pkg::ST_MIM;
                    launch_next = 1'b1;
                end
            end
            asbc_pkg::ST_MIM:
            begin
                if (mul_done)
                begin
                    state_next  = asbc_pkg::ST_SQX;
                    launch_next = 1'b1;
                end
            end
            asbc_pkg::ST_SQX:
            begin
                if (mul_done)
                begin
                    state_next  = asbc_pkg::ST_SQY;
                    launch_next = 1'b1;
                end
            end
            asbc_pkg::ST_SQY:
            begin
                if (mul_done)
                begin
                    state_next  = asbc_pkg::ST_SQC;
                    launch_next = 1'b1;
                end
            end
            asbc_pkg::ST_SQC:
            begin
                if (mul_done)
                begin
                    state_next = asbc_pkg::ST_CLASS;
                end
            end
            asbc_pkg::ST_CLASS:
            begin
                if (op_reg == asbc_pkg::OP_LOAD)
                begin
                    state_next = asbc_pkg::ST_IDLE;
                end
                else
                begin
                    state_next  = asbc_pkg::ST_SQRT1;
                    launch_next = 1'b1;
                end
            end
            asbc_pkg::ST_SQRT1:
            begin
                if (sqrt_done)
                begin
                    state_next  = asbc_pkg::ST_SQRT2;
                    launch_next = 1'b1;
                end
            end
            asbc_pkg::ST_SQRT2:
            begin
                if (sqrt_done)
                begin
                    state_next  = asbc_pkg::ST_DIV;
                    launch_next = 1'b1;
                end
            end
            asbc_pkg::ST_DIV:
            begin
                if (launch_reg ? div_short : (div_cnt_reg == 5'd1))
                begin
                    state_next = asbc_pkg::ST_OUT;
                end
            end
            asbc_pkg::ST_OUT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    state_next = asbc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = asbc_pkg::ST_IDLE;
            end
        endcase
    end

    logic out_load;
    assign out_load = (state_reg == asbc_pkg::ST_OUT) && (!out_valid_reg || rsp.ready);

    // Control state, configuration and frame accumulators.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= asbc_pkg::ST_IDLE;
            launch_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            pitch_x_reg   <= asbc_pkg::PITCH_RESET;
            pitch_y_reg   <= asbc_pkg::PITCH_RESET;
            cutoff_reg    <= asbc_pkg::PITCH_RESET;
            max_reg       <= '0;
            prop_reg      <= '0;
            total_reg     <= '0;
            pcnt_reg      <= '0;
            ecnt_reg      <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            launch_reg <= launch_next;

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (psel && penable && pwrite)
            begin
                unique case (paddr[3:2])
                    asbc_pkg::REG_PITCH_X: pitch_x_reg <= pwdata;
                    asbc_pkg::REG_PITCH_Y: pitch_y_reg <= pwdata;
                    asbc_pkg::REG_CUTOFF:  cutoff_reg  <= pwdata;
                    default:
                    begin
                    end
                endcase
            end

            if (req_fire && (req_op == asbc_pkg::OP_CLEAR))
            begin
                max_reg   <= '0;
                prop_reg  <= '0;
                total_reg <= '0;
                pcnt_reg  <= '0;
                ecnt_reg  <= '0;
            end
            else if ((state_reg == asbc_pkg::ST_CLASS) && (op_reg == asbc_pkg::OP_LOAD))
            begin
                if (m_reg > max_reg)
                begin
                    max_reg <= m_reg;
                end
                total_reg <= total_sum[EW] ? asbc_pkg::ENERGY_MAX : total_sum[EW-1:0];
                if (!cls_cur)
                begin
                    prop_reg <= prop_sum[EW] ? asbc_pkg::ENERGY_MAX : prop_sum[EW-1:0];
                    if (pcnt_reg != asbc_pkg::COUNT_MAX)
                    begin
                        pcnt_reg <= pcnt_reg + 1'b1;
                    end
                end
                else if (ecnt_reg != asbc_pkg::COUNT_MAX)
                begin
                    ecnt_reg <= ecnt_reg + 1'b1;
                end
            end
        end
    end

    // Working datapath.
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            op_reg <= req_op;
            fx_reg <= sat_freq(sidx_x, pitch_x_reg);
            fy_reg <= sat_freq(sidx_y, pitch_y_reg);
            re_reg <= req.coeff_re;
            im_reg <= req.coeff_im;
        end
        if (state_reg == asbc_pkg::ST_RDWAIT)
        begin
            re_reg <= rdata[CFW-1:0];
            im_reg <= rdata[2*CFW-1:CFW];
        end
        if (mul_done)
        begin
            unique case (state_reg)
                asbc_pkg::ST_MRE: re2_reg <= mul_prod[MAGW-1:0];
                asbc_pkg::ST_MIM: m_reg   <= mag_sat;
                asbc_pkg::ST_SQX: sqx_reg <= mul_prod;
                asbc_pkg::ST_SQY: sqy_reg <= mul_prod;
                default:          csq_reg <= mul_prod;
            endcase
        end
        if (state_reg == asbc_pkg::ST_CLASS)
        begin
            sq_reg   <= sq_cur;
            diff_reg <= diff_cur;
            cls_reg  <= cls_cur;
        end
        if (sqrt_done)
        begin
            if (state_reg == asbc_pkg::ST_SQRT1)
            begin
                radial_reg <= sqrt_root[FW-1:0];
            end
            else
            begin
                axial_reg <= sqrt_root[FW-1:0];
            end
        end

        // Fraction by restoring long division, one quotient bit a cycle.
        if (state_reg == asbc_pkg::ST_DIV)
        begin
            if (launch_reg)
            begin
                div_r_reg   <= {1'b0, div_num};
                div_cnt_reg <= 5'd16;
                if (div_den == '0)
                begin
                    div_q_reg <= '0;
                end
                else if (div_num >= div_den)
                begin
                    div_q_reg <= asbc_pkg::FRAC_ONE;
                end
                else
                begin
                    div_q_reg <= '0;
                end
            end
            else
            begin
                div_cnt_reg <= div_cnt_reg - 1'b1;
                if (div_r2 >= {1'b0, div_den})
                begin
                    div_r_reg <= div_r2 - {1'b0, div_den};
                    div_q_reg <= {div_q_reg[QW-2:0], 1'b1};
                end
                else
                begin
                    div_r_reg <= div_r2;
                    div_q_reg <= {div_q_reg[QW-2:0], 1'b0};
                end
            end
        end

        // Response payload.
        if (out_load)
        begin
            if (op_reg == asbc_pkg::OP_SUMMARY)
            begin
                o_fx_reg     <= '0;
                o_fy_reg     <= '0;
                o_radial_reg <= '0;
                o_re_reg     <= '0;
                o_im_reg     <= '0;
                o_inten_reg  <= '0;
                o_cls_reg    <= 1'b0;
                o_axial_reg  <= '0;
                o_pcnt_reg   <= pcnt_reg;
                o_ecnt_reg   <= ecnt_reg;
                o_frac_reg   <= div_q_reg;
                o_ez_reg     <= (total_reg == '0);
            end
            else
            begin
                o_fx_reg     <= fx_reg;
                o_fy_reg     <= fy_reg;
                o_radial_reg <= radial_reg;
                o_re_reg     <= re_reg;
                o_im_reg     <= im_reg;
                o_inten_reg  <= div_q_reg;
                o_cls_reg    <= cls_reg;
                o_axial_reg  <= axial_reg;
                o_pcnt_reg   <= '0;
                o_ecnt_reg   <= '0;
                o_frac_reg   <= '0;
                o_ez_reg     <= 1'b0;
            end
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.freq_x         = o_fx_reg;
    assign rsp.freq_y         = o_fy_reg;
    assign rsp.radial         = o_radial_reg;
    assign rsp.bin_re         = o_re_reg;
    assign rsp.bin_im         = o_im_reg;
    assign rsp.intensity      = o_inten_reg;
    assign rsp.bin_class      = o_cls_reg;
    assign rsp.axial_or_decay = o_axial_reg;
    assign rsp.prop_count     = o_pcnt_reg;
    assign rsp.evan_count     = o_ecnt_reg;
    assign rsp.prop_fraction  = o_frac_reg;
    assign rsp.energy_zero    = o_ez_reg;

    // Register readback.
    assign pready = 1'b1;
    always_comb
    begin
        unique case (paddr[3:2])
            asbc_pkg::REG_PITCH_X: prdata = pitch_x_reg;
            asbc_pkg::REG_PITCH_Y: prdata = pitch_y_reg;
            asbc_pkg::REG_CUTOFF:  prdata = cutoff_reg;
            default:               prdata = '0;
        endcase
    end

endmodule
